@@ hdl/chr_pkg.sv @@
// Shared types and constants for the hash ring router.
// No dependencies; every other file imports this package.
package chr_pkg;

  localparam int RING_DEPTH_DEF = 256;
  localparam int NUM_NODES_DEF  = 16;
  localparam int HASH_W         = 64;
  localparam int NODE_W         = 4;
  localparam int NODE_FIELD_N   = 16;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_HEALTH = 2'd1,
    CMD_ROUTE  = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_TARGET = 2'd1,
    ST_UNKNOWN   = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_PICK
  } fsm_t;

  // Control from the sequencer to every ring cell.
  typedef struct packed {
    logic ins_commit;
    logic flag_sample;
  } cell_ctrl_t;

endpackage

@@ hdl/chr_cell.sv @@
// One ring slot: holds a point hash and its owner, shifts on insert.
// Depends on chr_pkg.
module chr_cell
  import chr_pkg::*;
#(
  parameter int IDX   = 0,
  parameter int CNT_W = 9
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cell_ctrl_t              ctrl,
  input  logic [CNT_W-1:0]        count,
  input  logic [HASH_W-1:0]       key,
  input  logic [NODE_W-1:0]       new_owner,
  input  logic [NODE_FIELD_N-1:0] health_vec,
  input  logic                    prev_le,
  input  logic [HASH_W-1:0]       prev_hash,
  input  logic [NODE_W-1:0]       prev_owner,
  output logic                    le,
  output logic [HASH_W-1:0]       hash,
  output logic [NODE_W-1:0]       owner,
  output logic                    ge_flag,
  output logic                    hl_flag
);

  logic [HASH_W-1:0] hash_r, hash_nxt;
  logic [NODE_W-1:0] owner_r, owner_nxt;
  logic              ge_r, ge_nxt;
  logic              hl_r, hl_nxt;
  logic              valid;
  logic              lt;

  assign valid = (count > CNT_W'(IDX));
  assign lt    = (hash_r < key);
  assign le    = valid && (lt || (hash_r == key));

  // Sorted ring: the cells with le set form a prefix, so the first cell
  // without it takes the new point and all later cells take their neighbour.
  always_comb begin
    hash_nxt  = hash_r;
    owner_nxt = owner_r;
    if (ctrl.ins_commit && !le) begin
      if (prev_le) begin
        hash_nxt  = key;
        owner_nxt = new_owner;
      end else begin
        hash_nxt  = prev_hash;
        owner_nxt = prev_owner;
      end
    end
  end

  always_comb begin
    ge_nxt = ge_r;
    hl_nxt = hl_r;
    if (ctrl.flag_sample) begin
      ge_nxt = valid && !lt;
      hl_nxt = valid && health_vec[owner_r];
    end
  end

  always_ff @(posedge clk) begin
    hash_r  <= hash_nxt;
    owner_r <= owner_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ge_r <= 1'b0;
      hl_r <= 1'b0;
    end else begin
      ge_r <= ge_nxt;
      hl_r <= hl_nxt;
    end
  end

  assign hash    = hash_r;
  assign owner   = owner_r;
  assign ge_flag = ge_r;
  assign hl_flag = hl_r;

endmodule

@@ hdl/chr_pick.sv @@
// Priority pick over the registered cell flags for a route.
// Depends on chr_pkg.
module chr_pick
  import chr_pkg::*;
#(
  parameter int DEPTH = 256
) (
  input  logic [DEPTH-1:0]  ge_vec,
  input  logic [DEPTH-1:0]  hl_vec,
  input  logic [NODE_W-1:0] owners [DEPTH],
  output logic              found,
  output logic [NODE_W-1:0] owner
);

  logic [DEPTH-1:0] cand;
  logic [DEPTH-1:0] vec;
  logic [DEPTH-1:0] first;

  // Healthy points at or above the key come first; failing that the walk
  // wraps to the lowest healthy point on the ring.
  assign cand  = ge_vec & hl_vec;
  assign vec   = (|cand) ? cand : hl_vec;
  assign first = vec & (~vec + DEPTH'(1));
  assign found = |vec;

  always_comb begin
    owner = '0;
    for (int i = 0; i < DEPTH; i++) begin
      owner = owner | (owners[i] & {NODE_W{first[i]}});
    end
  end

endmodule

@@ hdl/consistent_hash_ring_router_top.sv @@
// Top level of the hash ring router: sequencer, node tables and cell chain.
// Depends on chr_pkg, chr_cell and chr_pick.
//
//   Channel  Direction  Signals
//   in       input      in_valid, in_ready, in_cmd, in_hash_value, in_node_index,
//                       in_node_healthy
//   out      output     out_valid, out_ready, out_status, out_route_node
//
// Insert, set health and unused commands pass through the execute state and back
// to idle; a route then passes through the pick state across the cell chain.
// Reset empties the ring and clears the node known and health bits at once.
// A result waits in the output register; the sequencer holds its last step while
// that register is still full, and takes no new item until it has loaded it.
module consistent_hash_ring_router_top
  import chr_pkg::*;
#(
  parameter int RING_DEPTH = RING_DEPTH_DEF,
  parameter int NUM_NODES  = NUM_NODES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_cmd,
  input  logic [HASH_W-1:0] in_hash_value,
  input  logic [NODE_W-1:0] in_node_index,
  input  logic              in_node_healthy,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_status,
  output logic [NODE_W-1:0] out_route_node
);

  localparam int CNT_W      = $clog2(RING_DEPTH + 1);
  localparam int NODE_SLOTS = (NUM_NODES < NODE_FIELD_N) ? NUM_NODES : NODE_FIELD_N;

  fsm_t state_r, state_nxt;

  logic [1:0]        cmd_r;
  logic [HASH_W-1:0] hash_r;
  logic [NODE_W-1:0] node_r;
  logic              healthy_r;

  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [NODE_SLOTS-1:0] known_r, known_nxt;
  logic [NODE_SLOTS-1:0] health_r, health_nxt;

  logic          out_valid_r, out_valid_nxt;
  status_t       status_r, status_nxt;
  logic [NODE_W-1:0] route_r, route_nxt;

  logic       in_xfer;
  logic       out_free;
  logic       out_load;
  cell_ctrl_t ctrl;

  logic [NODE_FIELD_N-1:0] known16;
  logic [NODE_FIELD_N-1:0] health16;
  logic                    node_ok;
  logic                    full;
  status_t                 exec_status;

  logic              le_w    [RING_DEPTH];
  logic [HASH_W-1:0] hash_w  [RING_DEPTH];
  logic [NODE_W-1:0] owner_w [RING_DEPTH];
  logic [RING_DEPTH-1:0] ge_vec;
  logic [RING_DEPTH-1:0] hl_vec;
  logic              pick_found;
  logic [NODE_W-1:0] pick_owner;

  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    known16  = '0;
    health16 = '0;
    for (int j = 0; j < NODE_SLOTS; j++) begin
      known16[j]  = known_r[j];
      health16[j] = health_r[j];
    end
  end

  assign node_ok = (32'(node_r) < NUM_NODES);
  assign full    = (count_r == CNT_W'(RING_DEPTH));

  always_comb begin
    exec_status = ST_OK;
    unique case (cmd_t'(cmd_r))
      CMD_INSERT: begin
        if (!node_ok) begin
          exec_status = ST_UNKNOWN;
        end else if (full) begin
          exec_status = ST_FULL;
        end
      end
      CMD_HEALTH: begin
        if (!node_ok || !known16[node_r]) begin
          exec_status = ST_UNKNOWN;
        end
      end
      CMD_ROUTE:  exec_status = ST_OK;
      CMD_NOP:    exec_status = ST_OK;
      default:    exec_status = ST_OK;
    endcase
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (cmd_t'(cmd_r) == CMD_ROUTE) begin
          state_nxt = S_PICK;
        end else if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_PICK: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready         = 1'b0;
    out_load         = 1'b0;
    ctrl.ins_commit  = 1'b0;
    ctrl.flag_sample = 1'b0;
    unique case (state_r)
      S_IDLE: in_ready = 1'b1;
      S_EXEC: begin
        if (cmd_t'(cmd_r) == CMD_ROUTE) begin
          ctrl.flag_sample = 1'b1;
        end else if (out_free) begin
          out_load        = 1'b1;
          ctrl.ins_commit = (cmd_t'(cmd_r) == CMD_INSERT) && (exec_status == ST_OK);
        end
      end
      S_PICK: out_load = out_free;
      default: in_ready = 1'b0;
    endcase
  end

  always_comb begin
    count_nxt  = count_r;
    known_nxt  = known_r;
    health_nxt = health_r;
    if (ctrl.ins_commit) begin
      count_nxt = count_r + CNT_W'(1);
    end
    if (out_load && (state_r == S_EXEC) && (exec_status == ST_OK)) begin
      for (int j = 0; j < NODE_SLOTS; j++) begin
        if (node_r == NODE_W'(j)) begin
          if (cmd_t'(cmd_r) == CMD_INSERT) begin
            known_nxt[j]  = 1'b1;
            health_nxt[j] = healthy_r;
          end else if (cmd_t'(cmd_r) == CMD_HEALTH) begin
            health_nxt[j] = healthy_r;
          end
        end
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    status_nxt    = status_r;
    route_nxt     = route_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
      if (state_r == S_PICK) begin
        status_nxt = pick_found ? ST_OK : ST_NO_TARGET;
        route_nxt  = pick_found ? pick_owner : '0;
      end else begin
        status_nxt = exec_status;
        route_nxt  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      known_r     <= '0;
      health_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      known_r     <= known_nxt;
      health_r    <= health_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cmd_r     <= in_cmd;
      hash_r    <= in_hash_value;
      node_r    <= in_node_index;
      healthy_r <= in_node_healthy;
    end
    status_r <= status_nxt;
    route_r  <= route_nxt;
  end

  genvar g;
  generate
    for (g = 0; g < RING_DEPTH; g++) begin : g_cell
      logic              p_le;
      logic [HASH_W-1:0] p_hash;
      logic [NODE_W-1:0] p_owner;

      if (g == 0) begin : g_head
        assign p_le    = 1'b1;
        assign p_hash  = hash_r;
        assign p_owner = node_r;
      end else begin : g_link
        assign p_le    = le_w[g-1];
        assign p_hash  = hash_w[g-1];
        assign p_owner = owner_w[g-1];
      end

      chr_cell #(
        .IDX   (g),
        .CNT_W (CNT_W)
      ) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .count      (count_r),
        .key        (hash_r),
        .new_owner  (node_r),
        .health_vec (health16),
        .prev_le    (p_le),
        .prev_hash  (p_hash),
        .prev_owner (p_owner),
        .le         (le_w[g]),
        .hash       (hash_w[g]),
        .owner      (owner_w[g]),
        .ge_flag    (ge_vec[g]),
        .hl_flag    (hl_vec[g])
      );
    end
  endgenerate

  chr_pick #(
    .DEPTH (RING_DEPTH)
  ) u_pick (
    .ge_vec (ge_vec),
    .hl_vec (hl_vec),
    .owners (owner_w),
    .found  (pick_found),
    .owner  (pick_owner)
  );

  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_route_node = route_r;

endmodule
